/* sv/afs_pkg.sv */
`timescale 1ns / 1ps

package afs_pkg;

  // frame counter width; the counter saturates at its all-ones value
  localparam int LENGTH_BITS = 24;
  localparam int FRAME_LEN_W = 24;
  localparam int CODE_LEN_W  = 3;
  localparam int NAL_TYPE_W  = 5;
  localparam int WINDOW_LEN  = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef logic [LENGTH_BITS-1:0] count_t;
  typedef logic [NAL_TYPE_W-1:0]  nal_type_t;

  localparam count_t     COUNT_MAX  = {LENGTH_BITS{1'b1}};
  localparam logic [7:0] TYPE_MASK  = 8'h1f;
  localparam nal_type_t  TYPE_SPS   = 5'h07;
  localparam nal_type_t  TYPE_PPS   = 5'h08;
  localparam logic [CODE_LEN_W-1:0] SHORT_CODE = 3'd3;
  localparam logic [CODE_LEN_W-1:0] LONG_CODE  = 3'd4;

  // one result word
  typedef struct packed {
    logic [FRAME_LEN_W-1:0] frame_length;
    logic                   stream_end;
  } result_t;

  // pushes into the result queue for one accepted byte
  typedef struct packed {
    logic push0;
    logic push1;
  } push_t;

endpackage

/* sv/afs_if.sv */
`timescale 1ns / 1ps

// input byte channel
interface afs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

// result channel
interface afs_out_if;
  logic                            valid;
  logic                            ready;
  logic [afs_pkg::FRAME_LEN_W-1:0] frame_length;
  logic                            stream_end;

  modport source (output valid, output frame_length, output stream_end, input ready);
  modport sink (input valid, input frame_length, input stream_end, output ready);
endinterface

// configuration write channel
interface afs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [afs_pkg::CODE_LEN_W-1:0] start_code_length;

  modport source (output valid, output start_code_length, input ready);
  modport sink (input valid, input start_code_length, output ready);
endinterface

/* sv/h264_annexb_frame_splitter_core.sv */
`timescale 1ns / 1ps

// Scans an H.264 Annex B byte stream at one byte per clock and reports frame
// lengths. A row of four byte cells shifts the stream along each accepted
// byte; a 3- or 4-byte start code sitting wholly inside the current frame,
// followed by a NAL header that is neither SPS nor PPS, ends the frame once
// the skip armed by reset, by a final byte or by a PPS has been cleared.
// Results pass through a four-word queue, and the input is ready whenever
// that queue holds at most two words, so a byte is taken every clock as long
// as results are drained at the rate they appear. The final byte of a stream
// always yields a closing word and returns the scanner to its start state.
// The user writes the start code length only while idle; no check is made.
module h264_annexb_frame_splitter_core (
  input  logic      clk,
  input  logic      rst,
  afs_in_if.sink    byte_in,
  afs_out_if.source frame_out,
  afs_cfg_if.sink   cfg
);

  logic [afs_pkg::CODE_LEN_W-1:0]  start_code_length;
  afs_pkg::count_t                 frame_byte_count;
  afs_pkg::count_t                 count_next;
  afs_pkg::count_t                 count_mid;
  afs_pkg::count_t                 code_len;
  afs_pkg::count_t                 split_len;
  logic                            skip_pending;
  logic                            skip_next;
  logic [afs_pkg::QUEUE_CNT_W-1:0] level;
  logic [7:0]                      win_byte [afs_pkg::WINDOW_LEN];
  logic [afs_pkg::WINDOW_LEN-1:0]  win_zero;
  logic [afs_pkg::WINDOW_LEN-1:0]  win_one;
  logic                            accept;
  logic                            short_code;
  logic                            code_seen;
  logic                            code_hit;
  logic                            split;
  afs_pkg::nal_type_t              nal_type;
  afs_pkg::push_t                  push;
  afs_pkg::result_t                data0;
  afs_pkg::result_t                data1;

  assign accept        = byte_in.valid && byte_in.ready;
  assign byte_in.ready = (level <= afs_pkg::QUEUE_CNT_W'(afs_pkg::QUEUE_DEPTH - 2));
  assign cfg.ready     = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      start_code_length <= afs_pkg::LONG_CODE;
    end else if (cfg.valid && cfg.ready) begin
      start_code_length <= cfg.start_code_length;
    end
  end

  // byte window: newest byte in the last cell
  for (genvar i = 0; i < afs_pkg::WINDOW_LEN; i++) begin : g_cell
    logic [7:0] feed;
    if (i == afs_pkg::WINDOW_LEN - 1) begin : g_head
      assign feed = byte_in.data_byte;
    end else begin : g_body
      assign feed = win_byte[i+1];
    end
    afs_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .shift   (accept),
      .clear   (byte_in.final_byte),
      .byte_in (feed),
      .byte_q  (win_byte[i]),
      .is_zero (win_zero[i]),
      .is_one  (win_one[i])
    );
  end

  // start code detection and frame split decision
  always_comb begin
    short_code = (start_code_length == afs_pkg::SHORT_CODE);
    code_len   = short_code ? afs_pkg::count_t'(afs_pkg::SHORT_CODE)
                            : afs_pkg::count_t'(afs_pkg::LONG_CODE);
    code_seen  = win_zero[1] && win_zero[2] && win_one[3] && (short_code || win_zero[0]);
    code_hit   = accept && code_seen && (frame_byte_count >= code_len);
    nal_type   = afs_pkg::NAL_TYPE_W'(byte_in.data_byte & afs_pkg::TYPE_MASK);
    split      = code_hit && !skip_pending
                 && (nal_type != afs_pkg::TYPE_SPS) && (nal_type != afs_pkg::TYPE_PPS);
    split_len  = (frame_byte_count == afs_pkg::COUNT_MAX) ? afs_pkg::COUNT_MAX
                                                           : frame_byte_count - code_len;
    count_mid  = split ? code_len : frame_byte_count;
    count_next = (count_mid == afs_pkg::COUNT_MAX) ? count_mid
                                                    : count_mid + afs_pkg::count_t'(1);
  end

  // skip flag update
  always_comb begin
    skip_next = skip_pending;
    if (code_hit) begin
      if (nal_type == afs_pkg::TYPE_PPS) begin
        skip_next = 1'b1;
      end else if (nal_type != afs_pkg::TYPE_SPS) begin
        skip_next = 1'b0;
      end
    end
    if (accept && byte_in.final_byte) begin
      skip_next = 1'b1;
    end
  end

  // frame counter and skip flag
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_byte_count <= '0;
      skip_pending     <= 1'b1;
    end else if (accept) begin
      frame_byte_count <= byte_in.final_byte ? '0 : count_next;
      skip_pending     <= skip_next;
    end
  end

  // result words for this byte
  always_comb begin
    push.push0         = split || (accept && byte_in.final_byte);
    push.push1         = split && byte_in.final_byte;
    data0.frame_length = split ? afs_pkg::FRAME_LEN_W'(split_len)
                               : afs_pkg::FRAME_LEN_W'(count_next);
    data0.stream_end   = !split;
    data1.frame_length = afs_pkg::FRAME_LEN_W'(count_next);
    data1.stream_end   = 1'b1;
  end

  afs_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .data0     (data0),
    .data1     (data1),
    .level     (level),
    .frame_out (frame_out)
  );

  // queue never overfills
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    level <= afs_pkg::QUEUE_CNT_W'(afs_pkg::QUEUE_DEPTH))
    else $error("result queue overfilled");

  // a closing byte returns the scanner to its start state
  a_final_clear: assert property (@(posedge clk) disable iff (rst)
    accept && byte_in.final_byte |=> frame_byte_count == '0 && skip_pending)
    else $error("scanner not cleared after final byte");

  // no frame ends while the skip is armed
  a_no_split_skip: assert property (@(posedge clk) disable iff (rst)
    skip_pending |-> !split)
    else $error("frame split while skip armed");

  // a split restarts the count at the start code plus the header byte
  a_split_count: assert property (@(posedge clk) disable iff (rst)
    split && !byte_in.final_byte |=> frame_byte_count == $past(code_len) + afs_pkg::count_t'(1))
    else $error("frame count wrong after split");

endmodule

/* sv/afs_cell.sv */
`timescale 1ns / 1ps

module afs_cell (
  input  logic       clk,
  input  logic       rst,
  input  logic       shift,
  input  logic       clear,
  input  logic [7:0] byte_in,
  output logic [7:0] byte_q,
  output logic       is_zero,
  output logic       is_one
);

  logic [7:0] stored;

  // hold one window byte, pass it on at each shift, zero it on a clearing shift
  always_ff @(posedge clk) begin
    if (rst) begin
      stored <= '0;
    end else if (shift) begin
      stored <= clear ? 8'h00 : byte_in;
    end
  end

  assign byte_q  = stored;
  assign is_zero = (stored == 8'h00);
  assign is_one  = (stored == 8'h01);

endmodule

/* sv/afs_outq.sv */
`timescale 1ns / 1ps

module afs_outq (
  input  logic                               clk,
  input  logic                               rst,
  input  afs_pkg::push_t                     push,
  input  afs_pkg::result_t                   data0,
  input  afs_pkg::result_t                   data1,
  output logic [afs_pkg::QUEUE_CNT_W-1:0]    level,
  afs_out_if.source                          frame_out
);

  afs_pkg::result_t                  slots [afs_pkg::QUEUE_DEPTH];
  logic [afs_pkg::QUEUE_PTR_W-1:0]   wr_ptr;
  logic [afs_pkg::QUEUE_PTR_W-1:0]   rd_ptr;
  logic [afs_pkg::QUEUE_CNT_W-1:0]   level_next;
  logic [afs_pkg::QUEUE_PTR_W-1:0]   wr_ptr_next;
  logic                              pop;
  logic [1:0]                        push_cnt;

  assign pop      = frame_out.valid && frame_out.ready;
  assign push_cnt = {1'b0, push.push0} + {1'b0, push.push1};

  // level and write pointer after this cycle
  always_comb begin
    level_next  = level + afs_pkg::QUEUE_CNT_W'(push_cnt)
                  - afs_pkg::QUEUE_CNT_W'(pop);
    wr_ptr_next = wr_ptr + afs_pkg::QUEUE_PTR_W'(push_cnt);
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      level  <= level_next;
      if (pop) begin
        rd_ptr <= rd_ptr + afs_pkg::QUEUE_PTR_W'(1);
      end
    end
  end

  // result words, up to two written per cycle
  always_ff @(posedge clk) begin
    if (push.push0) begin
      slots[wr_ptr] <= data0;
    end
    if (push.push1) begin
      slots[wr_ptr + afs_pkg::QUEUE_PTR_W'(1)] <= data1;
    end
  end

  assign frame_out.valid        = (level != '0);
  assign frame_out.frame_length = slots[rd_ptr].frame_length;
  assign frame_out.stream_end   = slots[rd_ptr].stream_end;

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam int LIMIT_CYCLES  = 500000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 20;
  localparam int LONG_HOLD     = 150;
  localparam int PHASE_BYTES   = 60;
  localparam int DRAIN_STREAMS = 4;

  logic clk = 1'b0;
  logic rst;

  afs_in_if  byte_if ();
  afs_out_if frame_if ();
  afs_cfg_if cfg_if ();

  h264_annexb_frame_splitter_core uut (
    .clk       (clk),
    .rst       (rst),
    .byte_in   (byte_if),
    .frame_out (frame_if),
    .cfg       (cfg_if)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scanner mirror: register, byte window, frame count, skip flag
  logic [afs_pkg::CODE_LEN_W-1:0] code_len_reg;
  logic [7:0]                     win [afs_pkg::WINDOW_LEN];
  afs_pkg::count_t                frame_cnt;
  logic                           skip_armed;
  afs_pkg::result_t               frames_due [$];

  // stream under construction
  logic [7:0] stream_q [$];

  // idle and stall controls
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_reqs      = 0;

  // run statistics
  int fails       = 0;
  int bytes_sent  = 0;
  int frames_seen = 0;
  int ends_seen   = 0;
  int cycles      = 0;
  afs_pkg::result_t want;

  function automatic void clear_scan();
    for (int i = 0; i < afs_pkg::WINDOW_LEN; i++) win[i] = 8'h00;
    frame_cnt  = '0;
    skip_armed = 1'b1;
  endfunction

  // advance the mirror by one byte and queue the frame words it yields
  function automatic void scan_byte(input logic [7:0] b, input logic last);
    afs_pkg::count_t    code_n;
    logic               seen;
    afs_pkg::nal_type_t nt;
    afs_pkg::result_t   r;
    code_n = (code_len_reg == afs_pkg::SHORT_CODE) ? afs_pkg::count_t'(afs_pkg::SHORT_CODE)
                                                   : afs_pkg::count_t'(afs_pkg::LONG_CODE);
    nt     = b[afs_pkg::NAL_TYPE_W-1:0];
    seen   = (win[1] == 8'h00) && (win[2] == 8'h00) && (win[3] == 8'h01);
    if (code_n == afs_pkg::count_t'(afs_pkg::LONG_CODE)) seen = seen && (win[0] == 8'h00);
    // start code fully inside the current frame
    if (seen && frame_cnt >= code_n) begin
      if (nt != afs_pkg::TYPE_SPS && nt != afs_pkg::TYPE_PPS) begin
        if (!skip_armed) begin
          r.frame_length = (frame_cnt == afs_pkg::COUNT_MAX) ? afs_pkg::COUNT_MAX
                                                             : frame_cnt - code_n;
          r.stream_end   = 1'b0;
          frames_due.push_back(r);
          frame_cnt = code_n;
        end else begin
          skip_armed = 1'b0;
        end
      end else if (nt == afs_pkg::TYPE_PPS) begin
        skip_armed = 1'b1;
      end
    end
    if (frame_cnt != afs_pkg::COUNT_MAX) frame_cnt = frame_cnt + 1'b1;
    win[0] = win[1];
    win[1] = win[2];
    win[2] = win[3];
    win[3] = b;
    // remainder on the last byte
    if (last) begin
      r.frame_length = frame_cnt;
      r.stream_end   = 1'b1;
      frames_due.push_back(r);
      clear_scan();
    end
  endfunction

  // receiver: random stalls plus requested long hold-offs
  initial begin
    int hold_left;
    int hold_served;
    hold_left      = 0;
    hold_served    = 0;
    frame_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_served) begin
        hold_served = hold_reqs;
        hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        frame_if.ready <= 1'b0;
      end else begin
        frame_if.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // compare each accepted frame word with the oldest expectation
  always @(posedge clk) begin
    if (!rst && frame_if.valid && frame_if.ready) begin
      frames_seen++;
      if (frame_if.stream_end) ends_seen++;
      if (frames_due.size() == 0) begin
        $error("unexpected frame word: frame_length=%0d stream_end=%0b",
               frame_if.frame_length, frame_if.stream_end);
        fails++;
      end else begin
        want = frames_due.pop_front();
        if (frame_if.frame_length !== want.frame_length) begin
          $error("frame_length: expected %0d, got %0d", want.frame_length,
                 frame_if.frame_length);
          fails++;
        end
        if (frame_if.stream_end !== want.stream_end) begin
          $error("stream_end: expected %0b, got %0b", want.stream_end, frame_if.stream_end);
          fails++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d frame words outstanding", cycles,
               frames_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // one byte on the input channel, with optional idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      byte_if.valid <= 1'b0;
      @(negedge clk);
    end
    byte_if.valid      <= 1'b1;
    byte_if.data_byte  <= b;
    byte_if.final_byte <= last;
    do @(posedge clk); while (!byte_if.ready);
    scan_byte(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_stream();
    for (int i = 0; i < stream_q.size(); i++) send_byte(stream_q[i], i == stream_q.size() - 1);
  endtask

  // stop offering bytes until every expected frame word has come back
  task automatic wait_drained();
    byte_if.valid <= 1'b0;
    while (frames_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_code_length(input logic [afs_pkg::CODE_LEN_W-1:0] v);
    wait_drained();
    cfg_if.valid             <= 1'b1;
    cfg_if.start_code_length <= v;
    do @(posedge clk); while (!cfg_if.ready);
    code_len_reg = v;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  // random stream: mostly start-code framed NALs, some noise and broken codes
  task automatic build_stream();
    int                 nals;
    int                 kind;
    int                 pick;
    afs_pkg::nal_type_t nt;
    stream_q.delete();
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(1, 6)) stream_q.push_back(8'($urandom));
      return;
    end
    nals = $urandom_range(1, 6);
    for (int k = 0; k < nals; k++) begin
      kind = $urandom_range(9);
      // long code, short code, or a broken one
      if (kind <= 5) stream_q.push_back(8'h00);
      stream_q.push_back(8'h00);
      stream_q.push_back(8'h00);
      stream_q.push_back((kind == 9) ? 8'($urandom_range(2, 255)) : 8'h01);
      pick = $urandom_range(9);
      if (pick <= 2)      nt = afs_pkg::TYPE_SPS;
      else if (pick <= 4) nt = afs_pkg::TYPE_PPS;
      else if (pick <= 6) nt = 5'd5;
      else if (pick <= 8) nt = 5'd1;
      else                nt = afs_pkg::nal_type_t'($urandom);
      stream_q.push_back({3'($urandom), nt});
      // payload with frequent zero and one bytes
      repeat ($urandom_range(0, 5)) begin
        pick = $urandom_range(7);
        stream_q.push_back((pick == 0) ? 8'h00 : (pick == 1) ? 8'h01 : 8'($urandom));
      end
    end
  endtask

  task automatic run_streams(input int n_bytes);
    int sent;
    sent = 0;
    while (sent < n_bytes) begin
      build_stream();
      send_stream();
      sent += stream_q.size();
    end
  endtask

  // hand-built streams for the named cases
  task automatic test_directed();
    // long code: sps passed over, idr clears skip, slice ends frame on the final byte
    stream_q = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h67, 8'h00, 8'h00, 8'h00, 8'h01, 8'he5,
                 8'h00, 8'h00, 8'h00, 8'h01, 8'h41};
    send_stream();
    // short code: pps re-arms, non-idr clears, next nal splits on the final byte
    write_code_length(afs_pkg::SHORT_CODE);
    stream_q = '{8'h00, 8'h00, 8'h01, 8'h68, 8'h00, 8'h00, 8'h01, 8'h01,
                 8'h00, 8'h00, 8'h01, 8'h25};
    send_stream();
    // out-of-range setting acts as long; code overlapping cleared window zeros is ignored
    write_code_length(3'd7);
    stream_q = '{8'h00, 8'h01, 8'hff};
    send_stream();
  endtask

  task automatic test_no_idle();
    write_code_length(afs_pkg::SHORT_CODE);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_streams(PHASE_BYTES);
  endtask

  task automatic test_sender_idle();
    write_code_length(3'd0);
    send_idle_pct  = 81;
    recv_stall_pct = 0;
    run_streams(PHASE_BYTES);
  endtask

  task automatic test_receiver_stall();
    write_code_length(afs_pkg::SHORT_CODE);
    send_idle_pct  = 0;
    recv_stall_pct = 81;
    run_streams(PHASE_BYTES);
  endtask

  task automatic test_both_idle();
    write_code_length(3'($urandom));
    send_idle_pct  = 37;
    recv_stall_pct = 37;
    run_streams(PHASE_BYTES);
  endtask

  // long receiver hold-off while one-byte streams keep arriving
  task automatic test_backpressure();
    write_code_length(afs_pkg::LONG_CODE);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_reqs      <= hold_reqs + 1;
    repeat (30) send_byte(8'($urandom), 1'b1);
    run_streams(10);
  endtask

  // sender pauses after every stream until all frame words are back
  task automatic test_drain_pause();
    write_code_length(afs_pkg::SHORT_CODE);
    send_idle_pct  = 0;
    recv_stall_pct = 20;
    repeat (DRAIN_STREAMS) begin
      build_stream();
      send_stream();
      wait_drained();
    end
  endtask

  initial begin
    rst                      = 1'b1;
    byte_if.valid            = 1'b0;
    byte_if.data_byte        = 8'h00;
    byte_if.final_byte       = 1'b0;
    cfg_if.valid             = 1'b0;
    cfg_if.start_code_length = afs_pkg::LONG_CODE;
    code_len_reg             = afs_pkg::LONG_CODE;
    clear_scan();
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_backpressure();
    test_drain_pause();

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (frames_due.size() != 0) begin
      $error("%0d expected frame words never arrived", frames_due.size());
      fails++;
    end
    $display("scanned %0d stream bytes under 3- and 4-byte start codes and odd settings,",
             bytes_sent);
    $display("with idle, stall and hold-off phases: %0d frame words (%0d at stream end)",
             frames_seen, ends_seen);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
sv/afs_pkg.sv
sv/afs_if.sv
sv/afs_cell.sv
sv/afs_outq.sv
sv/h264_annexb_frame_splitter_core.sv
sim/tb.sv
